@@ hw/rtl/hbkpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbkpd_pkg
// shared types and constants of the boot keyboard press detector
// ----------------------------------------------------------------------------
package hbkpd_pkg;

  localparam int unsigned CodeW = 8;

  localparam logic [CodeW-1:0] ShiftMask   = 8'h22;  // left/right shift
  localparam logic [CodeW-1:0] ControlMask = 8'h11;  // left/right control
  localparam logic [CodeW-1:0] CapsCode    = 8'h39;
  localparam logic [CodeW-1:0] FirstKey    = 8'h04;  // lower codes are errors

  // what one lane found for its slot
  typedef struct packed {
    logic emit;    // new press of an ordinary key
    logic toggle;  // new press of caps lock
  } lane_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/hid_boot_keyboard_press_detect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_boot_keyboard_press_detect
// finds new key presses in usb hid boot keyboard reports
// ----------------------------------------------------------------------------
// Each input item is one boot keyboard report (modifier byte and KEY_SLOTS
// key slots). Every slot holding a usage code of 4 or more that was absent
// from the previous report is a new press. Caps lock (0x39) toggles the
// internal caps flag and sends nothing; every other new press sends one
// item with the code, shift and control of this report and the caps flag as
// it stands at that slot. The last event of a report carries tlast; a report
// with no new press sends nothing. Timing: its events leave the pending
// buffer one a cycle while the output register is free or the sink takes
// its event; the next report is taken in the cycle the last pending event
// moves to the output register. The single output register lets the next
// report be taken while a finished event waits for the sink.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_press_detect #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // report in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // modifier_byte [7:0], key_slot_0 [15:8], key_slot_1 .. upward a byte each
  input  wire logic [8*(KEY_SLOTS+1)-1:0]  s_axis_tdata,
  // press events out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // key_code [7:0]
  output logic [7:0]                       m_axis_tdata,
  // shift_held [0], control_held [1], caps_on [2]
  output logic [2:0]                       m_axis_tuser,
  // last_event
  output logic                             m_axis_tlast
);

  localparam int unsigned CW = hbkpd_pkg::CodeW;

  logic [KEY_SLOTS-1:0][CW-1:0]          prev_q;
  logic                                  caps_q, caps_d;
  logic [KEY_SLOTS-1:0][CW-1:0]          slots;
  logic [CW-1:0]                         mods;
  hbkpd_pkg::lane_res_t [KEY_SLOTS-1:0]  lane_res;
  logic [KEY_SLOTS-1:0]                  emit;
  logic [KEY_SLOTS-1:0]                  caps_at;
  logic                                  accept;
  logic                                  shift, control;

  assign mods = s_axis_tdata[CW-1:0];

  // unpack slots and run one compare lane per slot
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    assign slots[g] = s_axis_tdata[CW*(g+1) +: CW];

    hbkpd_lane #(
      .KEY_SLOTS (KEY_SLOTS)
    ) u_lane (
      .code_i      (slots[g]),
      .prev_keys_i (prev_q),
      .res_o       (lane_res[g])
    );
  end

  hbkpd_merge #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_merge (
    .lane_i      (lane_res),
    .caps_i      (caps_q),
    .emit_o      (emit),
    .caps_o      (caps_at),
    .caps_next_o (caps_d)
  );

  assign shift   = |(mods & hbkpd_pkg::ShiftMask);
  assign control = |(mods & hbkpd_pkg::ControlMask);
  assign accept  = s_axis_tvalid && s_axis_tready;

  // previous report and caps flag advance as each report is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      caps_q <= 1'b0;
    end else if (accept) begin
      prev_q <= slots;
      caps_q <= caps_d;
    end
  end

  hbkpd_drain #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .emit_i      (emit),
    .caps_i      (caps_at),
    .codes_i     (slots),
    .shift_i     (shift),
    .control_i   (control),
    .can_load_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (m_axis_tdata),
    .out_flags_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // an event never carries caps lock or an error code
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= hbkpd_pkg::FirstKey &&
                       m_axis_tdata != hbkpd_pkg::CapsCode))
    else $error("event with invalid key code");

  // a report's events follow without a gap once one is taken
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("report events interrupted");

  // modifiers stay the same within one report
  a_mods_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tuser[1:0] == $past(m_axis_tuser[1:0])))
    else $error("modifiers changed within one report");

endmodule
`default_nettype wire

@@ hw/rtl/hbkpd_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbkpd_lane
// checks one key slot against the previous report
// ----------------------------------------------------------------------------
module hbkpd_lane #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic [hbkpd_pkg::CodeW-1:0]                code_i,
  input  wire logic [KEY_SLOTS-1:0][hbkpd_pkg::CodeW-1:0] prev_keys_i,
  output hbkpd_pkg::lane_res_t                            res_o
);

  logic [KEY_SLOTS-1:0] hit;
  logic                 new_press;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit[i] = (prev_keys_i[i] == code_i);
    end
  end

  assign new_press    = (code_i >= hbkpd_pkg::FirstKey) && !(|hit);
  assign res_o.toggle = new_press && (code_i == hbkpd_pkg::CapsCode);
  assign res_o.emit   = new_press && (code_i != hbkpd_pkg::CapsCode);

endmodule
`default_nettype wire

@@ hw/rtl/hbkpd_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbkpd_merge
// combines lane results: event mask and caps state seen at each slot
// ----------------------------------------------------------------------------
module hbkpd_merge #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire hbkpd_pkg::lane_res_t [KEY_SLOTS-1:0] lane_i,
  input  wire logic                                 caps_i,
  output logic [KEY_SLOTS-1:0]                      emit_o,
  output logic [KEY_SLOTS-1:0]                      caps_o,
  output logic                                      caps_next_o
);

  logic [KEY_SLOTS:0] caps_run;

  // running parity of caps toggles, slot by slot
  always_comb begin
    caps_run[0] = caps_i;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      emit_o[i]     = lane_i[i].emit;
      caps_o[i]     = caps_run[i];
      caps_run[i+1] = caps_run[i] ^ lane_i[i].toggle;
    end
  end

  assign caps_next_o = caps_run[KEY_SLOTS];

endmodule
`default_nettype wire

@@ hw/rtl/hbkpd_drain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbkpd_drain
// holds one report's pending events and sends them one a cycle while the output register can take them
// ----------------------------------------------------------------------------
module hbkpd_drain #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        load_i,
  input  wire logic [KEY_SLOTS-1:0]                        emit_i,
  input  wire logic [KEY_SLOTS-1:0]                        caps_i,
  input  wire logic [KEY_SLOTS-1:0][hbkpd_pkg::CodeW-1:0]  codes_i,
  input  wire logic                                        shift_i,
  input  wire logic                                        control_i,
  output logic                                             can_load_o,
  output logic                                             out_valid_o,
  input  wire logic                                        out_ready_i,
  output logic [hbkpd_pkg::CodeW-1:0]                      out_code_o,
  output logic [2:0]                                       out_flags_o,
  output logic                                             out_last_o
);

  logic [KEY_SLOTS-1:0]                       mask_q, mask_d;
  logic [KEY_SLOTS-1:0]                       caps_q;
  logic [KEY_SLOTS-1:0][hbkpd_pkg::CodeW-1:0] codes_q;
  logic                                       shift_q, control_q;
  logic [KEY_SLOTS-1:0]                       pick, rest;
  logic [hbkpd_pkg::CodeW-1:0]                pick_code;
  logic                                       pick_caps;
  logic                                       drain_fire;
  logic                                       ov_q;
  logic [hbkpd_pkg::CodeW-1:0]                code_q;
  logic [2:0]                                 flags_q;
  logic                                       last_q;

  // lowest pending slot goes first
  assign pick = mask_q & (~mask_q + KEY_SLOTS'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    pick_code = '0;
    pick_caps = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      pick_code = pick_code | (codes_q[i] & {hbkpd_pkg::CodeW{pick[i]}});
      pick_caps = pick_caps | (caps_q[i] & pick[i]);
    end
  end

  assign drain_fire = (|mask_q) && (!ov_q || out_ready_i);
  assign can_load_o = !(|mask_q) || (drain_fire && !(|rest));

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = emit_i;
    end else if (drain_fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (drain_fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      codes_q   <= codes_i;
      caps_q    <= caps_i;
      shift_q   <= shift_i;
      control_q <= control_i;
    end
    if (drain_fire) begin
      code_q  <= pick_code;
      flags_q <= {pick_caps, control_q, shift_q};
      last_q  <= !(|rest);
    end
  end

  assign out_valid_o = ov_q;
  assign out_code_o  = code_q;
  assign out_flags_o = flags_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire
